/* rtl/tfd_pkg.sv */
// Shared types, widths and constants for the threshold fall detector.
// Used by every module of the block; depends on nothing else.
package tfd_pkg;

    // Accelerometer window length and the widths that follow from it.
    localparam int WINDOW = 4;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 16 + SLOT_W;

    // Field widths.
    localparam int ACC_W     = 16;
    localparam int RATE_W    = 22;
    localparam int PRES_W    = 24;
    localparam int ACC_SQ_W  = 31;
    localparam int RATE_SQ_W = 43;
    localparam int BASE_W    = 32;

    // Stream and register port widths.
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 8;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // Register reset values.
    localparam logic [31:0] LOW_G_LIMIT_RST = 32'd156185;
    localparam logic [43:0] SPIN_LIMIT_RST  = 44'd5206164098;
    localparam logic [15:0] RISE_LIMIT_RST  = 16'd614;
    localparam logic [7:0]  MIN_TICKS_RST   = 8'd3;
    localparam logic [7:0]  QUIET_TICKS_RST = 8'd20;
    localparam logic [8:0]  EMA_WEIGHT_RST  = 9'd26;

    // Counter ceiling and full-scale baseline weight.
    localparam logic [7:0] COUNT_MAX  = 8'd255;
    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_LOW_G_LIMIT = 3'd0,
        REG_SPIN_LIMIT  = 3'd1,
        REG_RISE_LIMIT  = 3'd2,
        REG_MIN_TICKS   = 3'd3,
        REG_QUIET_TICKS = 3'd4,
        REG_EMA_WEIGHT  = 3'd5
    } t_reg_idx;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic [31:0] low_g_limit;
        logic [43:0] spin_limit;
        logic [15:0] rise_limit;
        logic [7:0]  min_low_g_ticks;
        logic [7:0]  quiet_ticks;
        logic [8:0]  ema_weight;
    } t_cfg;

    // One captured input item.
    typedef struct packed {
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [PRES_W-1:0]        pressure;
        logic                     button;
    } t_sample;

    // Item after window averaging.
    typedef struct packed {
        logic signed [ACC_W-1:0]  avg_x;
        logic signed [ACC_W-1:0]  avg_y;
        logic signed [ACC_W-1:0]  avg_z;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [PRES_W-1:0]        pressure;
        logic                     button;
    } t_feat;

    // Item after squaring.
    typedef struct packed {
        logic [ACC_SQ_W-1:0]  acc_sq_x;
        logic [ACC_SQ_W-1:0]  acc_sq_y;
        logic [ACC_SQ_W-1:0]  acc_sq_z;
        logic [RATE_SQ_W-1:0] rate_sq_x;
        logic [RATE_SQ_W-1:0] rate_sq_y;
        logic [RATE_SQ_W-1:0] rate_sq_z;
        logic [PRES_W-1:0]    pressure;
        logic                 button;
    } t_energy;

endpackage

/* rtl/tfd_cfg.sv */
// Configuration register file with an APB-style access port.
// Depends on tfd_pkg for the register indexes, reset values and t_cfg.
module tfd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output tfd_pkg::t_cfg                   o_cfg
);

    logic [31:0]       r_low_g_limit;
    logic [43:0]       r_spin_limit;
    logic [15:0]       r_rise_limit;
    logic [7:0]        r_min_ticks;
    logic [7:0]        r_quiet_ticks;
    logic [8:0]        r_ema_weight;
    logic              wr_en;
    tfd_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = tfd_pkg::t_reg_idx'(paddr[5:3]);

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_g_limit <= tfd_pkg::LOW_G_LIMIT_RST;
            r_spin_limit  <= tfd_pkg::SPIN_LIMIT_RST;
            r_rise_limit  <= tfd_pkg::RISE_LIMIT_RST;
            r_min_ticks   <= tfd_pkg::MIN_TICKS_RST;
            r_quiet_ticks <= tfd_pkg::QUIET_TICKS_RST;
            r_ema_weight  <= tfd_pkg::EMA_WEIGHT_RST;
        end else if (wr_en) begin
            case (idx)
                tfd_pkg::REG_LOW_G_LIMIT: r_low_g_limit <= pwdata[31:0];
                tfd_pkg::REG_SPIN_LIMIT:  r_spin_limit  <= pwdata[43:0];
                tfd_pkg::REG_RISE_LIMIT:  r_rise_limit  <= pwdata[15:0];
                tfd_pkg::REG_MIN_TICKS:   r_min_ticks   <= pwdata[7:0];
                tfd_pkg::REG_QUIET_TICKS: r_quiet_ticks <= pwdata[7:0];
                tfd_pkg::REG_EMA_WEIGHT:  r_ema_weight  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (idx)
            tfd_pkg::REG_LOW_G_LIMIT: prdata = 64'(r_low_g_limit);
            tfd_pkg::REG_SPIN_LIMIT:  prdata = 64'(r_spin_limit);
            tfd_pkg::REG_RISE_LIMIT:  prdata = 64'(r_rise_limit);
            tfd_pkg::REG_MIN_TICKS:   prdata = 64'(r_min_ticks);
            tfd_pkg::REG_QUIET_TICKS: prdata = 64'(r_quiet_ticks);
            tfd_pkg::REG_EMA_WEIGHT:  prdata = 64'(r_ema_weight);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.low_g_limit     = r_low_g_limit;
    assign o_cfg.spin_limit      = r_spin_limit;
    assign o_cfg.rise_limit      = r_rise_limit;
    assign o_cfg.min_low_g_ticks = r_min_ticks;
    assign o_cfg.quiet_ticks     = r_quiet_ticks;
    assign o_cfg.ema_weight      = r_ema_weight;

endmodule

/* rtl/tfd_window.sv */
// Sliding window of accelerometer samples with per-axis running sums and averages.
// Depends on tfd_pkg for WINDOW, widths and the t_sample and t_feat types.
module tfd_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tfd_pkg::t_sample i_sample,
    output tfd_pkg::t_feat   o_feat
);

    logic signed [tfd_pkg::ACC_W-1:0] r_hist [3][tfd_pkg::WINDOW];
    logic signed [tfd_pkg::SUM_W-1:0] r_sum [3];
    logic [tfd_pkg::SLOT_W-1:0]       r_slot;
    tfd_pkg::t_feat                   r_feat;

    logic signed [tfd_pkg::ACC_W-1:0] acc [3];
    logic signed [tfd_pkg::SUM_W-1:0] n_sum [3];
    logic signed [tfd_pkg::ACC_W-1:0] avg [3];
    logic signed [31:0]               quot [3];
    logic [tfd_pkg::SLOT_W-1:0]       n_slot;

    assign acc[0] = i_sample.accel_x;
    assign acc[1] = i_sample.accel_y;
    assign acc[2] = i_sample.accel_z;

    // Replace the oldest sample in each running sum and average it,
    // truncating toward zero.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sum[a] = r_sum[a] - tfd_pkg::SUM_W'(r_hist[a][r_slot])
                     + tfd_pkg::SUM_W'(acc[a]);
            quot[a]  = 32'(n_sum[a]) / tfd_pkg::WINDOW;
            avg[a]   = quot[a][tfd_pkg::ACC_W-1:0];
        end
    end

    // Window position wraps at the window length.
    assign n_slot = (r_slot == tfd_pkg::SLOT_W'(tfd_pkg::WINDOW - 1))
                  ? '0 : r_slot + 1'b1;

    // Window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
                for (int k = 0; k < tfd_pkg::WINDOW; k++) begin
                    r_hist[a][k] <= '0;
                end
            end
        end else if (i_load) begin
            r_slot <= n_slot;
            for (int a = 0; a < 3; a++) begin
                r_sum[a]          <= n_sum[a];
                r_hist[a][r_slot] <= acc[a];
            end
        end
    end

    // Stage output register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_feat.avg_x    <= avg[0];
            r_feat.avg_y    <= avg[1];
            r_feat.avg_z    <= avg[2];
            r_feat.rate_x   <= i_sample.rate_x;
            r_feat.rate_y   <= i_sample.rate_y;
            r_feat.rate_z   <= i_sample.rate_z;
            r_feat.pressure <= i_sample.pressure;
            r_feat.button   <= i_sample.button;
        end
    end

    assign o_feat = r_feat;

endmodule

/* rtl/tfd_energy.sv */
// Squares of the averaged acceleration and of the angular rates, one multiplier each.
// Depends on tfd_pkg for widths and the t_feat and t_energy types.
module tfd_energy (
    input  logic             i_clk,
    input  logic             i_load,
    input  tfd_pkg::t_feat   i_feat,
    output tfd_pkg::t_energy o_energy
);

    logic signed [31:0] sq_ax;
    logic signed [31:0] sq_ay;
    logic signed [31:0] sq_az;
    logic signed [43:0] sq_rx;
    logic signed [43:0] sq_ry;
    logic signed [43:0] sq_rz;
    tfd_pkg::t_energy   r_energy;

    // All squares are non-negative, so the upper sign bit is dropped.
    assign sq_ax = 32'(i_feat.avg_x) * 32'(i_feat.avg_x);
    assign sq_ay = 32'(i_feat.avg_y) * 32'(i_feat.avg_y);
    assign sq_az = 32'(i_feat.avg_z) * 32'(i_feat.avg_z);
    assign sq_rx = 44'(i_feat.rate_x) * 44'(i_feat.rate_x);
    assign sq_ry = 44'(i_feat.rate_y) * 44'(i_feat.rate_y);
    assign sq_rz = 44'(i_feat.rate_z) * 44'(i_feat.rate_z);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_energy.acc_sq_x  <= sq_ax[tfd_pkg::ACC_SQ_W-1:0];
            r_energy.acc_sq_y  <= sq_ay[tfd_pkg::ACC_SQ_W-1:0];
            r_energy.acc_sq_z  <= sq_az[tfd_pkg::ACC_SQ_W-1:0];
            r_energy.rate_sq_x <= sq_rx[tfd_pkg::RATE_SQ_W-1:0];
            r_energy.rate_sq_y <= sq_ry[tfd_pkg::RATE_SQ_W-1:0];
            r_energy.rate_sq_z <= sq_rz[tfd_pkg::RATE_SQ_W-1:0];
            r_energy.pressure  <= i_feat.pressure;
            r_energy.button    <= i_feat.button;
        end
    end

    assign o_energy = r_energy;

endmodule

/* rtl/tfd_decide.sv */
// Low-g counting, pressure baseline, fall decision and alarm latch; holds the result register.
// Depends on tfd_pkg for widths, constants and the t_cfg and t_energy types.
module tfd_decide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tfd_pkg::t_energy i_energy,
    input  tfd_pkg::t_cfg    i_cfg,
    output logic             o_alarm,
    output logic             o_fall_now,
    output logic             o_low_g_now
);

    logic [7:0]                  r_low_g_ticks;
    logic [7:0]                  r_quiet_count;
    logic [tfd_pkg::BASE_W-1:0]  r_baseline;
    logic                        r_alarm;
    logic                        r_fall;
    logic                        r_low_g;

    logic [31:0]                 acc_sum;
    logic [44:0]                 rate_sum;
    logic                        low_g;
    logic                        spin;
    logic [8:0]                  w;
    logic [8:0]                  inv_w;
    logic [41:0]                 ema_acc;
    logic [tfd_pkg::BASE_W-1:0]  n_baseline;
    logic signed [33:0]          rise;
    logic signed [33:0]          rise_thr;
    logic [7:0]                  n_low_g_ticks;
    logic [7:0]                  n_quiet_count;
    logic                        n_fall;
    logic                        n_alarm;

    // Energy sums and threshold tests.
    assign acc_sum  = 32'(i_energy.acc_sq_x) + 32'(i_energy.acc_sq_y)
                    + 32'(i_energy.acc_sq_z);
    assign rate_sum = 45'(i_energy.rate_sq_x) + 45'(i_energy.rate_sq_y)
                    + 45'(i_energy.rate_sq_z);
    assign low_g    = acc_sum < i_cfg.low_g_limit;
    assign spin     = rate_sum > 45'(i_cfg.spin_limit);

    // Exponential baseline; weights above full scale act as full scale.
    assign w          = i_cfg.ema_weight[8] ? tfd_pkg::WEIGHT_ONE : i_cfg.ema_weight;
    assign inv_w      = tfd_pkg::WEIGHT_ONE - w;
    assign ema_acc    = 42'(inv_w) * 42'(r_baseline)
                      + ((42'(w) * 42'(i_energy.pressure)) << 8);
    assign n_baseline = (r_low_g_ticks == '0) ? ema_acc[39:8] : r_baseline;

    // Pressure rise over the updated baseline, both in 1/2^20 hPa.
    assign rise     = $signed({2'b00, i_energy.pressure, 8'h00})
                    - $signed({2'b00, n_baseline});
    assign rise_thr = $signed({10'd0, i_cfg.rise_limit, 8'h00});

    // Counters, fall decision and alarm.
    always_comb begin
        n_low_g_ticks = r_low_g_ticks;
        n_quiet_count = r_quiet_count;
        if (low_g) begin
            if (r_low_g_ticks != tfd_pkg::COUNT_MAX) begin
                n_low_g_ticks = r_low_g_ticks + 8'd1;
            end
            n_quiet_count = '0;
        end else begin
            if (r_quiet_count != tfd_pkg::COUNT_MAX) begin
                n_quiet_count = r_quiet_count + 8'd1;
            end
            if (n_quiet_count > i_cfg.quiet_ticks) begin
                n_low_g_ticks = '0;
            end
        end
        n_fall = (n_low_g_ticks >= i_cfg.min_low_g_ticks) && (spin || (rise > rise_thr));
        if (n_fall) begin
            n_low_g_ticks = '0;
        end
        n_alarm = (r_alarm | n_fall) & ~i_energy.button;
    end

    // Persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_g_ticks <= '0;
            r_quiet_count <= '0;
            r_baseline    <= '0;
            r_alarm       <= 1'b0;
        end else if (i_load) begin
            r_low_g_ticks <= n_low_g_ticks;
            r_quiet_count <= n_quiet_count;
            r_baseline    <= n_baseline;
            r_alarm       <= n_alarm;
        end
    end

    // Per-item result flags.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fall  <= n_fall;
            r_low_g <= low_g;
        end
    end

    assign o_alarm     = r_alarm;
    assign o_fall_now  = r_fall;
    assign o_low_g_now = r_low_g;

endmodule

/* rtl/threshold_fall_detector.sv */
// Top level of the threshold fall detector: stream ports, pipeline control, stages.
// Depends on tfd_pkg, tfd_cfg, tfd_window, tfd_energy and tfd_decide.
//
//  Channel     Direction  Handshake                   Content
//  s_axis      in         s_axis_tvalid/tready        one sensor tick
//  m_axis      out        m_axis_tvalid/tready        alarm, fall and low-g flags
//  APB         in         psel/penable/pwrite/pready  six threshold registers
//
// Four register stages: input capture, window average, squaring, decision
// and result. One item is taken per cycle while the output is not stalled.
// Each stage holds its item only while the stage after it is full and
// stalled, so bubbles close up. Reset is synchronous, with no clearing pass.
module threshold_fall_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[69:48],
    // rate_y[91:70], rate_z[113:92], pressure[137:114], button[138], zeros above
    input  logic [tfd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // alarm[0], fall_now[1], low_g_now[2], zeros above
    output logic [tfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tfd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    tfd_pkg::t_cfg    cfg;
    tfd_pkg::t_sample in_sample;
    tfd_pkg::t_sample r_s1;
    tfd_pkg::t_feat   feat;
    tfd_pkg::t_energy energy;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             r_vo;
    logic             en1;
    logic             en2;
    logic             en3;
    logic             en_o;
    logic             alarm;
    logic             fall_now;
    logic             low_g_now;

    // Unpack the input item.
    assign in_sample.accel_x  = s_axis_tdata[15:0];
    assign in_sample.accel_y  = s_axis_tdata[31:16];
    assign in_sample.accel_z  = s_axis_tdata[47:32];
    assign in_sample.rate_x   = s_axis_tdata[69:48];
    assign in_sample.rate_y   = s_axis_tdata[91:70];
    assign in_sample.rate_z   = s_axis_tdata[113:92];
    assign in_sample.pressure = s_axis_tdata[137:114];
    assign in_sample.button   = s_axis_tdata[138];

    // A stage can load when it is empty or its item moves on this cycle.
    assign en_o = ~r_vo | m_axis_tready;
    assign en3  = ~r_v3 | en_o;
    assign en2  = ~r_v2 | en3;
    assign en1  = ~r_v1 | en2;

    assign s_axis_tready = en1;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    // Input capture register.
    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_s1 <= in_sample;
        end
    end

    tfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tfd_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (en2 & r_v1),
        .i_sample (r_s1),
        .o_feat   (feat)
    );

    tfd_energy u_energy (
        .i_clk    (i_clk),
        .i_load   (en3 & r_v2),
        .i_feat   (feat),
        .o_energy (energy)
    );

    tfd_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (en_o & r_v3),
        .i_energy    (energy),
        .i_cfg       (cfg),
        .o_alarm     (alarm),
        .o_fall_now  (fall_now),
        .o_low_g_now (low_g_now)
    );

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {5'b00000, low_g_now, fall_now, alarm};

endmodule

/* verif/fall_flag_checker.sv */
// Checker for the threshold fall detector: follows the register port and both stream
// channels, predicts the flags of every accepted tick and compares them in order.
// Depends on tfd_pkg for widths, register indexes and register reset values.
module fall_flag_checker
    import tfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_fall_total,
    output int                    o_low_g_total
);

    typedef struct packed {
        logic low_g_now;
        logic fall_now;
        logic alarm;
    } t_flags;

    // Shadow copy of the registers and of the detector state.
    t_cfg                    cfg;
    logic signed [ACC_W-1:0] accel_win [3][WINDOW];
    int unsigned             win_slot;
    logic [7:0]              low_g_run;
    logic [7:0]              quiet_run;
    logic [BASE_W-1:0]       base_level;
    logic                    alarm_held;

    // Flags predicted for ticks that went in but have not come out yet.
    t_flags flags_due [$];
    int     mismatches  = 0;
    int     falls_seen  = 0;
    int     low_g_seen  = 0;

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Advances the shadow state by one tick and returns the flags it should produce.
    function automatic t_flags detect_tick(input logic [IN_DATA_W-1:0] d);
        logic signed [ACC_W-1:0]  accel [3];
        logic signed [RATE_W-1:0] rate [3];
        logic [PRES_W-1:0]        pres;
        longint                   axis_sum;
        longint                   axis_avg;
        longint                   rate_val;
        longint unsigned          accel_energy;
        longint unsigned          spin_energy;
        longint unsigned          weight;
        longint unsigned          pres_scaled;
        longint                   rise;
        logic                     low_g;
        logic                     fall;
        t_flags                   res;

        accel[0] = d[15:0];
        accel[1] = d[31:16];
        accel[2] = d[47:32];
        rate[0]  = d[69:48];
        rate[1]  = d[91:70];
        rate[2]  = d[113:92];
        pres     = d[137:114];

        // Store the sample, then average each axis over the window (toward zero).
        for (int a = 0; a < 3; a++) accel_win[a][win_slot] = accel[a];
        win_slot = (win_slot + 1) % WINDOW;
        accel_energy = 0;
        spin_energy  = 0;
        for (int a = 0; a < 3; a++) begin
            axis_sum = 0;
            for (int k = 0; k < WINDOW; k++) axis_sum += accel_win[a][k];
            axis_avg = axis_sum / WINDOW;
            accel_energy += axis_avg * axis_avg;
            rate_val = rate[a];
            spin_energy += rate_val * rate_val;
        end

        // The baseline only follows the pressure while no low-g run is open.
        weight      = (cfg.ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.ema_weight;
        pres_scaled = {32'd0, pres, 8'd0};
        if (low_g_run == 8'd0) begin
            base_level = BASE_W'(((256 - weight) * base_level + weight * pres_scaled) >> 8);
        end

        // Low-g run length and the quiet timeout, both saturating.
        low_g = accel_energy < cfg.low_g_limit;
        if (low_g) begin
            if (low_g_run != COUNT_MAX) low_g_run = low_g_run + 8'd1;
            quiet_run = 8'd0;
        end else begin
            if (quiet_run != COUNT_MAX) quiet_run = quiet_run + 8'd1;
            if (quiet_run > cfg.quiet_ticks) low_g_run = 8'd0;
        end

        // A fall needs a long enough run plus either a spin or a pressure rise.
        rise = longint'(pres_scaled) - longint'(base_level);
        fall = 1'b0;
        if (low_g_run >= cfg.min_low_g_ticks &&
            (spin_energy > cfg.spin_limit || rise > longint'(cfg.rise_limit) * 256)) begin
            low_g_run  = 8'd0;
            fall       = 1'b1;
            alarm_held = 1'b1;
        end
        if (d[138]) alarm_held = 1'b0;

        falls_seen += fall;
        low_g_seen += low_g;
        res.alarm     = alarm_held;
        res.fall_now  = fall;
        res.low_g_now = low_g;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_flags want;
        if (!i_rst_n) begin
            cfg.low_g_limit     = LOW_G_LIMIT_RST;
            cfg.spin_limit      = SPIN_LIMIT_RST;
            cfg.rise_limit      = RISE_LIMIT_RST;
            cfg.min_low_g_ticks = MIN_TICKS_RST;
            cfg.quiet_ticks     = QUIET_TICKS_RST;
            cfg.ema_weight      = EMA_WEIGHT_RST;
            for (int a = 0; a < 3; a++)
                for (int k = 0; k < WINDOW; k++) accel_win[a][k] = '0;
            win_slot   = 0;
            low_g_run  = '0;
            quiet_run  = '0;
            base_level = '0;
            alarm_held = 1'b0;
            flags_due.delete();
        end else begin
            // Register writes land at the access edge.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:3]))
                    REG_LOW_G_LIMIT: cfg.low_g_limit     = i_pwdata[31:0];
                    REG_SPIN_LIMIT:  cfg.spin_limit      = i_pwdata[43:0];
                    REG_RISE_LIMIT:  cfg.rise_limit      = i_pwdata[15:0];
                    REG_MIN_TICKS:   cfg.min_low_g_ticks = i_pwdata[7:0];
                    REG_QUIET_TICKS: cfg.quiet_ticks     = i_pwdata[7:0];
                    REG_EMA_WEIGHT:  cfg.ema_weight      = i_pwdata[8:0];
                    default: ;
                endcase
            end

            // Results are compared before this edge's tick is predicted; the
            // pipeline delay keeps the two apart anyway.
            if (i_m_tvalid && i_m_tready) begin
                if (flags_due.size() == 0) begin
                    $error("result with no tick waiting: tdata %h", i_m_tdata);
                    mismatches++;
                end else begin
                    want = flags_due.pop_front();
                    compare_field("alarm", 8'(want.alarm), 8'(i_m_tdata[0]));
                    compare_field("fall_now", 8'(want.fall_now), 8'(i_m_tdata[1]));
                    compare_field("low_g_now", 8'(want.low_g_now), 8'(i_m_tdata[2]));
                    compare_field("tdata padding", 8'd0, 8'(i_m_tdata[OUT_DATA_W-1:3]));
                end
            end

            if (i_s_tvalid && i_s_tready) flags_due.push_back(detect_tick(i_s_tdata));
        end
        o_pending     <= flags_due.size();
        o_fail_count  <= mismatches;
        o_fall_total  <= falls_seen;
        o_low_g_total <= low_g_seen;
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the threshold fall detector: clock, reset, register setup,
// tick stimulus with random gaps and stalls, and the final verdict.
// Depends on tfd_pkg, threshold_fall_detector and fall_flag_checker.
module tb_top;
    import tfd_pkg::*;

    localparam int RESULT_LATENCY = 4;
    localparam int HOLD_CYCLES    = 160;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_TICKS    = 30;
    localparam int EXTREME_TICKS  = 20;
    localparam int SAT_RUN        = 258;
    localparam int QUIET_RUN      = 40;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Pacing controls for the sender and the receiver, and the watchdog's idle count.
    logic calm        = 1'b0;
    int   holds_asked = 0;
    int   holds_done  = 0;
    int   hold_left   = 0;
    int   idle_cycles = 0;

    // Bookkeeping for stimulus shaping and the summary.
    int          ticks_sent    = 0;
    int          settings_used = 0;
    logic [15:0] cur_rise      = RISE_LIMIT_RST;
    logic [7:0]  cur_min       = MIN_TICKS_RST;
    logic [7:0]  cur_quiet     = QUIET_TICKS_RST;

    int fail_count;
    int pending;
    int fall_total;
    int low_g_total;

    threshold_fall_detector dut (.*);

    fall_flag_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_fall_total  (fall_total),
        .o_low_g_total (low_g_total)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, a calm mode, and long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 34);
        end
    end

    // Watchdog: too many cycles in a row without any handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("No handshake for %0d cycles, %0d results outstanding.",
                     WATCHDOG_LIMIT, pending);
            $display("threshold_fall_detector verification failed");
            $finish;
        end
    end

    function automatic int signed_pick(input int lo, input int hi);
        int mag;
        mag = $urandom_range(lo, hi);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    function automatic logic [PRES_W-1:0] pressure_near(input int centre, input int spread);
        int p;
        p = centre + signed_pick(0, spread);
        if (p < 0) p = 0;
        if (p > 24'hFFFFFF) p = 24'hFFFFFF;
        return PRES_W'(p);
    endfunction

    // Fully random tick: every bit of every field is free.
    function automatic t_sample noise_tick();
        t_sample t;
        t.accel_x  = 16'($urandom);
        t.accel_y  = 16'($urandom);
        t.accel_z  = 16'($urandom);
        t.rate_x   = 22'($urandom);
        t.rate_y   = 22'($urandom);
        t.rate_z   = 22'($urandom);
        t.pressure = 24'($urandom);
        t.button   = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    // Plausible tick: at rest (about 1 g on z) or in free fall, slow or spinning.
    function automatic t_sample shape_tick(input logic free, input logic spin,
                                           input logic [PRES_W-1:0] pres, input logic btn);
        t_sample t;
        t.accel_x  = 16'(signed_pick(0, 200));
        t.accel_y  = 16'(signed_pick(0, 200));
        t.accel_z  = free ? 16'(signed_pick(0, 150)) : 16'(signed_pick(800, 1200));
        t.rate_x   = spin ? 22'(signed_pick(1500000, 2097151)) : 22'(signed_pick(0, 20000));
        t.rate_y   = spin ? 22'(signed_pick(1500000, 2097151)) : 22'(signed_pick(0, 20000));
        t.rate_z   = spin ? 22'(signed_pick(1500000, 2097151)) : 22'(signed_pick(0, 20000));
        t.pressure = pres;
        t.button   = btn;
        return t;
    endfunction

    // Sends one item, with random idle cycles ahead of it unless the phase is calm.
    task automatic push_tick(input t_sample t);
        if (!calm) begin
            while ($urandom_range(0, 99) < 34) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({t.button, t.pressure, t.rate_z, t.rate_y, t.rate_x,
                                     t.accel_z, t.accel_y, t.accel_x});
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_registers(input logic [31:0] low_g, input logic [43:0] spin,
                                 input logic [15:0] rise, input logic [7:0] min_ticks,
                                 input logic [7:0] quiet, input logic [8:0] weight);
        write_reg(REG_LOW_G_LIMIT, APB_DATA_W'(low_g));
        write_reg(REG_SPIN_LIMIT, APB_DATA_W'(spin));
        write_reg(REG_RISE_LIMIT, APB_DATA_W'(rise));
        write_reg(REG_MIN_TICKS, APB_DATA_W'(min_ticks));
        write_reg(REG_QUIET_TICKS, APB_DATA_W'(quiet));
        write_reg(REG_EMA_WEIGHT, APB_DATA_W'(weight));
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_rise  = rise;
        cur_min   = min_ticks;
        cur_quiet = quiet;
        settings_used++;
        @(posedge i_clk);
    endtask

    // Mostly realistic settings near the defaults, sometimes anything at all.
    task automatic random_registers();
        logic [31:0] low_g;
        logic [43:0] spin;
        logic [15:0] rise;
        logic [7:0]  min_ticks;
        logic [7:0]  quiet;
        logic [8:0]  weight;
        case ($urandom_range(0, 4))
            3:       low_g = $urandom_range(1000, 1 << 20);
            4:       low_g = $urandom;
            default: low_g = LOW_G_LIMIT_RST;
        endcase
        case ($urandom_range(0, 3))
            2:       spin = 44'($urandom_range(0, 1 << 30));
            3:       spin = 44'({$urandom, $urandom});
            default: spin = SPIN_LIMIT_RST;
        endcase
        rise      = ($urandom_range(0, 1) != 0) ? RISE_LIMIT_RST : 16'($urandom);
        min_ticks = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        quiet     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
        weight    = ($urandom_range(0, 1) != 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
        set_registers(low_g, spin, rise, min_ticks, quiet, weight);
    endtask

    // Mostly fall attempts (rest, free fall, then a spin, a pressure jump or
    // neither), with quiet stretches, broken runs and random noise in between.
    task automatic run_phase(input int n_ticks, input int hold_at, input int pause_at);
        int start;
        int base_p;
        int n;
        int trigger;
        start  = ticks_sent;
        base_p = $urandom_range(0, 24'hFFFFFF);
        while (ticks_sent - start < n_ticks) begin
            if (hold_at >= 0 && ticks_sent - start >= hold_at) begin
                holds_asked <= holds_asked + 1;
                hold_at = -1;
            end
            if (pause_at >= 0 && ticks_sent - start >= pause_at) begin
                settle();
                pause_at = -1;
            end
            if ($urandom_range(0, 7) == 0) base_p = $urandom_range(0, 24'hFFFFFF);
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) push_tick(noise_tick());
                end
                2: begin
                    n = (cur_quiet > 8'd38) ? 40 : int'(cur_quiet) + $urandom_range(1, 3);
                    repeat (n) push_tick(shape_tick(1'b0, 1'b0, pressure_near(base_p, 40),
                                                    ($urandom_range(0, 32) == 0)));
                end
                default: begin
                    repeat ($urandom_range(0, 4))
                        push_tick(shape_tick(1'b0, 1'b0, pressure_near(base_p, 40), 1'b0));
                    n = ((cur_min > 8'd10) ? 10 : int'(cur_min)) + $urandom_range(1, 4);
                    repeat (n) begin
                        push_tick(shape_tick(($urandom_range(0, 19) != 0), 1'b0,
                                             pressure_near(base_p, 40), 1'b0));
                    end
                    trigger = $urandom_range(0, 3);
                    case (trigger)
                        0: push_tick(shape_tick(1'b1, 1'b1, pressure_near(base_p, 40), 1'b0));
                        1: push_tick(shape_tick(1'b1, 1'b0, pressure_near(base_p + int'(cur_rise)
                                     + 2000, 1999), 1'b0));
                        2: push_tick(shape_tick(1'b1, 1'b0, pressure_near(base_p, 40), 1'b0));
                        default:
                           push_tick(shape_tick(1'b1, 1'b1, pressure_near(base_p, 40), 1'b1));
                    endcase
                    if ($urandom_range(0, 2) == 0)
                        push_tick(shape_tick(1'b0, 1'b0, pressure_near(base_p, 40), 1'b1));
                end
            endcase
        end
        settle();
    endtask

    initial begin
        t_sample probe;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero tick, both extremes, then falls by spin, by pressure
        // rise, and a fall on the same tick as the button.
        push_tick('0);
        probe = '{accel_x: 16'h7FFF, accel_y: 16'h7FFF, accel_z: 16'h7FFF,
                  rate_x: 22'h1FFFFF, rate_y: 22'h1FFFFF, rate_z: 22'h1FFFFF,
                  pressure: 24'hFFFFFF, button: 1'b0};
        push_tick(probe);
        probe = '{accel_x: 16'h8000, accel_y: 16'h8000, accel_z: 16'h8000,
                  rate_x: 22'h200000, rate_y: 22'h200000, rate_z: 22'h200000,
                  pressure: 24'h000000, button: 1'b1};
        push_tick(probe);
        repeat (4) push_tick(shape_tick(1'b1, 1'b0, 24'h100000, 1'b0));
        push_tick(shape_tick(1'b1, 1'b1, 24'h100000, 1'b0));
        push_tick(shape_tick(1'b0, 1'b0, 24'h100000, 1'b1));
        repeat (4) push_tick(shape_tick(1'b1, 1'b0, 24'h100000, 1'b0));
        push_tick(shape_tick(1'b1, 1'b0, 24'h102000, 1'b0));
        repeat (3) push_tick(shape_tick(1'b1, 1'b0, 24'h102000, 1'b0));
        push_tick(shape_tick(1'b1, 1'b1, 24'h102000, 1'b1));
        settle();

        // Every tick low-g, a zero minimum run, no quiet timeout, weight above one.
        set_registers(32'hFFFF_FFFF, 44'd0, 16'hFFFF, 8'd0, 8'd255, 9'd511);
        repeat (EXTREME_TICKS) push_tick(noise_tick());
        settle();

        // Nothing low-g, longest minimum run, immediate timeout, frozen baseline.
        set_registers(32'd0, 44'hFFF_FFFF_FFFF, 16'd0, 8'd255, 8'd0, 9'd0);
        repeat (EXTREME_TICKS) push_tick(noise_tick());
        settle();

        // Low-g run driven into saturation, a stretch of normal ticks with the
        // timeout disabled, then a fall on the saturated run.
        set_registers(LOW_G_LIMIT_RST, 44'hFFF_FFFF_FFFF, 16'hFFFF, 8'd255, 8'd255, 9'd256);
        repeat (SAT_RUN) push_tick(shape_tick(1'b1, 1'b0, 24'd0, 1'b0));
        repeat (QUIET_RUN) push_tick(shape_tick(1'b0, 1'b0, 24'd0, 1'b0));
        repeat (4) push_tick(shape_tick(1'b1, 1'b0, 24'hFFFFFF, 1'b0));
        settle();

        // Random settings; one calm phase, two receiver hold-offs, one sender pause.
        random_registers();
        calm <= 1'b1;
        run_phase(PHASE_TICKS, -1, -1);
        calm <= 1'b0;
        random_registers();
        run_phase(PHASE_TICKS, 10, -1);
        random_registers();
        run_phase(PHASE_TICKS, -1, 15);
        random_registers();
        run_phase(PHASE_TICKS, 8, -1);

        $display("Covered %0d ticks under %0d register settings: %0d falls, %0d low-g ticks.",
                 ticks_sent, settings_used + 1, fall_total, low_g_total);
        if (fail_count == 0 && pending == 0) begin
            $display("threshold_fall_detector verification clean");
        end else begin
            $display("threshold_fall_detector verification failed");
        end
        $finish;
    end

endmodule
